// ----- rtl/core/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, codes, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] vars_t;   // [0] = a ... [7] = h

  typedef enum logic [1:0] {
    FUNC_ABSORB  = 2'd0,
    FUNC_ABS_FIN = 2'd1,
    FUNC_FINISH  = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  // where the sequencer goes once a compression is done
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_PAD,
    JOB_LEN,
    JOB_OUT
  } job_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         LEN_STEP   = 8;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LEN_ROOM   = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_OUT   = 3'd7;

  localparam word_t H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/core/sha_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round plus one message schedule expansion step.
// ----------------------------------------------------------------------------
module sha_round
  import sha_pkg::*;
(
  input  vars_t v_i,
  input  word_t k_i,
  input  word_t w0_i,    // w[r]
  input  word_t w1_i,    // w[r+1]
  input  word_t w9_i,    // w[r+9]
  input  word_t w14_i,   // w[r+14]
  output vars_t v_o,
  output word_t w_new_o  // w[r+16]
);

  word_t s1, chv, t1, s0, maj, t2, sg0, sg1;

  always_comb begin
    s1  = rotr(v_i[4], 6) ^ rotr(v_i[4], 11) ^ rotr(v_i[4], 25);
    chv = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1  = v_i[7] + s1 + chv + k_i + w0_i;
    s0  = rotr(v_i[0], 2) ^ rotr(v_i[0], 13) ^ rotr(v_i[0], 22);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2  = s0 + maj;

    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;

    sg0     = rotr(w1_i, 7) ^ rotr(w1_i, 18) ^ (w1_i >> 3);
    sg1     = rotr(w14_i, 17) ^ rotr(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = w0_i + sg0 + w9_i + sg1;
  end

endmodule

// ----- rtl/core/sha256_byte_stream_hasher_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs a message one byte per input word and emits the 256-bit digest.
// ----------------------------------------------------------------------------
// Input channel: in_tuser selects absorb, absorb-and-finish or finish only;
// in_tdata carries the message byte. func code 3 is taken and ignored.
// Every 64th byte starts a block compression on the single shared round
// unit: a load step, 64 rounds and a step that folds the result into the
// hash, during all of which in_tready is low. A finish adds a step to place
// the pad byte, a step for the length and one or two compressions (two
// when fewer than 8 bytes are left in the block after the pad byte).
// Output channel: eight digest words, most significant first, out_tuser is
// the word index and out_tlast marks the eighth. The words leave through an
// output register; a stalled receiver holds the sequencer in its output step
// and back-pressures the input. After the last word is loaded the hasher is
// back at its initial state and takes the next message.
// Reset (rst_n low, synchronous) restores the initial hash values, clears
// the block buffer, bit length and byte position; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  word_t       hash_r [0:7];
  word_t       sched_r [0:15];
  vars_t       vars_r;
  logic [63:0] bitlen_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [2:0]  ocnt_r;

  logic        out_tvalid_r;
  word_t       out_tdata_r;
  logic [2:0]  out_tuser_r;
  logic        out_tlast_r;

  logic  in_acc, take_byte, out_load;
  func_t func;
  vars_t v_next;
  word_t w_new;

  assign func      = func_t'(in_tuser);
  assign in_acc    = in_tvalid && in_tready;
  assign take_byte = in_acc && (func == FUNC_ABSORB || func == FUNC_ABS_FIN);

  sha_round u_round (
    .v_i     (vars_r),
    .k_i     (ROUND_K[rnd_r]),
    .w0_i    (sched_r[0]),
    .w1_i    (sched_r[1]),
    .w9_i    (sched_r[9]),
    .w14_i   (sched_r[14]),
    .v_o     (v_next),
    .w_new_o (w_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_ABSORB, FUNC_ABS_FIN: begin
              if (pos_r == LAST_BYTE) begin
                state_nxt = ST_INIT;
                job_nxt   = (func == FUNC_ABS_FIN) ? JOB_PAD : JOB_NONE;
              end else if (func == FUNC_ABS_FIN) begin
                state_nxt = ST_PAD;
              end
            end
            FUNC_FINISH: state_nxt = ST_PAD;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PAD: begin
        if (pos_r >= LEN_ROOM) begin
          state_nxt = ST_INIT;
          job_nxt   = JOB_LEN;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        state_nxt = ST_INIT;
        job_nxt   = JOB_OUT;
      end
      ST_INIT:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == LAST_ROUND) state_nxt = ST_FINAL;
      ST_FINAL: begin
        case (job_r)
          JOB_PAD: state_nxt = ST_PAD;
          JOB_LEN: state_nxt = ST_LEN;
          JOB_OUT: state_nxt = ST_OUT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: if (out_load && ocnt_r == LAST_OUT) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_OUT:  out_load  = !out_tvalid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      job_r        <= JOB_NONE;
      bitlen_r     <= '0;
      pos_r        <= '0;
      rnd_r        <= '0;
      ocnt_r       <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 8; i++) hash_r[i] <= H_INIT[i];
      for (int i = 0; i < 16; i++) sched_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;

      if (out_tvalid_r && out_tready && !out_load) out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (take_byte) begin
            sched_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= in_tdata;
            pos_r    <= pos_r + 6'd1;
            bitlen_r <= bitlen_r + 64'(LEN_STEP);
          end
        end
        ST_PAD: begin
          sched_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= PAD_BYTE;
          pos_r <= pos_r + 6'd1;
        end
        ST_LEN: begin
          sched_r[14] <= bitlen_r[63:32];
          sched_r[15] <= bitlen_r[31:0];
          pos_r       <= '0;
        end
        ST_INIT: begin
          for (int i = 0; i < 8; i++) vars_r[i] <= hash_r[i];
          rnd_r <= '0;
        end
        ST_ROUND: begin
          vars_r <= v_next;
          for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i + 1];
          sched_r[15] <= w_new;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + vars_r[i];
          for (int i = 0; i < 16; i++) sched_r[i] <= '0;
        end
        ST_OUT: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= hash_r[ocnt_r];
            out_tuser_r  <= ocnt_r;
            out_tlast_r  <= (ocnt_r == LAST_OUT);
            ocnt_r       <= ocnt_r + 3'd1;
            if (ocnt_r == LAST_OUT) begin
              // message done: back to the initial state
              for (int i = 0; i < 8; i++) hash_r[i] <= H_INIT[i];
              bitlen_r <= '0;
              pos_r    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- rtl/core/sha_chk.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Checks the digest word sequence seen on the ports of the top level.
// ----------------------------------------------------------------------------
module sha_chk
  import sha_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // tlast sits on the eighth word only
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == LAST_OUT)))
    else $error("tlast does not match word index");

  // a taken word that is not the last is followed at once by the next index
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tuser == $past(out_tuser) + 3'd1))
    else $error("digest words not back to back in order");

  // no new input word is taken while a digest word other than the last is on the output
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready during digest output");

  // a word that rises after an idle output has index zero, the last index or the next index
  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && $past(in_tvalid && in_tready) == 1'b0 && !$past(out_tvalid))
      |-> (out_tuser == 3'd0 || out_tuser == LAST_OUT ||
           out_tuser == $past(out_tuser) + 3'd1))
    else $error("digest word index skipped");

  // a stalled word holds still until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("output word changed while stalled");

endmodule

bind sha256_byte_stream_hasher_core sha_chk u_sha_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- test/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both stream channels of the byte stream hasher. A local model of
// the hash state computes the digest at every finishing word and keeps the
// eight words in order; each word leaving the block is compared with them.
// ----------------------------------------------------------------------------
module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          words_due
);

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;   // length needs bytes 56..63

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  slot;
    logic        is_last;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [31:0]  block_words [16];
  logic [63:0]  msg_bits;
  logic [5:0]   fill_pos;
  digest_word_t digest_due [$];

  initial begin
    fail_count = 0;
    words_due = 0;
  end

  function automatic logic [31:0] rot_right(logic [31:0] x, int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  task automatic restart_message();
    hash_state = IV;
    foreach (block_words[i]) block_words[i] = '0;
    msg_bits = '0;
    fill_pos = '0;
  endtask

  // 64 rounds over the gathered block, added into the hash state, then the block is cleared
  task automatic fold_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] w15, w2, s0, s1, wv, t1, t2, ch, mj;
    w = block_words;
    v = hash_state;
    for (int r = 0; r < 64; r++) begin
      if (r < 16)
        wv = w[r];
      else begin
        w15 = w[(r - 15) & 15];
        w2 = w[(r - 2) & 15];
        s0 = rot_right(w15, 7) ^ rot_right(w15, 18) ^ (w15 >> 3);
        s1 = rot_right(w2, 17) ^ rot_right(w2, 19) ^ (w2 >> 10);
        wv = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = wv;
      end
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
           + ch + KTAB[r] + wv;
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22)) + mj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    foreach (hash_state[q]) hash_state[q] = hash_state[q] + v[q];
    foreach (block_words[i]) block_words[i] = '0;
  endtask

  // big-endian placement within each 32-bit word
  task automatic put_byte(logic [7:0] b);
    block_words[fill_pos[5:2]] |= {24'd0, b} << (24 - 8 * fill_pos[1:0]);
    fill_pos = fill_pos + 6'd1;
  endtask

  task automatic take_word(func_t f, logic [7:0] b);
    logic spill;
    if (f == FUNC_NONE) return;
    if (f != FUNC_FINISH) begin
      put_byte(b);
      msg_bits = msg_bits + 64'd8;
      if (fill_pos == '0) fold_block();
    end
    if (f == FUNC_ABSORB) return;
    // no room for the length: pad block goes out first, length in a fresh one
    spill = (fill_pos >= LEN_SLOT);
    put_byte(PAD_MARK);
    if (spill) fold_block();
    fill_pos = '0;
    block_words[14] = msg_bits[63:32];
    block_words[15] = msg_bits[31:0];
    fold_block();
    for (int q = 0; q < 8; q++)
      digest_due.push_back('{value: hash_state[q], slot: q[2:0], is_last: (q == 7)});
    restart_message();
  endtask

  task automatic check_word();
    digest_word_t exp_w;
    if (digest_due.size() == 0) begin
      $error("unexpected digest word %h (index %0d)", out_tdata, out_tuser);
      fail_count++;
      return;
    end
    exp_w = digest_due.pop_front();
    if (out_tdata !== exp_w.value) begin
      $error("digest_word mismatch: expected %h, actual %h", exp_w.value, out_tdata);
      fail_count++;
    end
    if (out_tuser !== exp_w.slot) begin
      $error("word_index mismatch: expected %0d, actual %0d", exp_w.slot, out_tuser);
      fail_count++;
    end
    if (out_tlast !== exp_w.is_last) begin
      $error("last_word mismatch: expected %0b, actual %0b", exp_w.is_last, out_tlast);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      digest_due.delete();
    end else begin
      if (in_tvalid && in_tready) take_word(func_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) check_word();
    end
    words_due = digest_due.size();
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds directed and random messages of assorted lengths, with ignored
// selector words mixed in, under changing input and output idling plus one
// long output hold-off; the digest checker compares every word.
// ----------------------------------------------------------------------------
module testbench;
  import sha_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 410;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int words_due;
  int bytes_sent = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 79;
  int stall_request = 0;
  int stall_left = 0;
  int cycle_count = 0;

  sha256_byte_stream_hasher_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sha256_digest_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sha256_byte_stream_hasher_core test failed");
      $finish;
    end
  end

  // receiver: random ready, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high from one word to the next unless an idle cycle falls in
  task automatic send_item(func_t f, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (f != FUNC_NONE) bytes_sent++;
  endtask

  task automatic send_message(int len, bit finish_alone);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_item(FUNC_NONE, 8'($urandom_range(255)));
      if (i == len - 1 && !finish_alone)
        send_item(FUNC_ABS_FIN, 8'($urandom_range(255)));
      else
        send_item(FUNC_ABSORB, 8'($urandom_range(255)));
    end
    if (len == 0 || finish_alone) send_item(FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  // mostly short messages, many right at the padding boundaries
  task automatic random_message();
    int pick;
    int len;
    int edges [4];
    edges = '{55, 56, 63, 64};
    pick = $urandom_range(99);
    if (pick < 40)
      len = $urandom_range(10);
    else if (pick < 70)
      len = edges[$urandom_range(3)];
    else if (pick < 80)
      len = $urandom_range(130, 100);
    else
      len = $urandom_range(54, 11);
    send_message(len, $urandom_range(1));
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_NONE;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored selector, empty message, single bytes, "abc"
    send_item(FUNC_NONE, 8'hAA);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_ABS_FIN, 8'h00);
    send_item(FUNC_ABSORB, 8'hFF);
    send_item(FUNC_NONE, 8'h55);
    send_item(FUNC_ABSORB, 8'h80);
    send_item(FUNC_ABS_FIN, 8'h01);
    send_item(FUNC_ABSORB, 8'h61);
    send_item(FUNC_ABSORB, 8'h62);
    send_item(FUNC_ABSORB, 8'h63);
    send_item(FUNC_FINISH, 8'hFF);
    send_item(FUNC_ABS_FIN, 8'hFF);
    send_item(FUNC_FINISH, 8'h7F);

    while (bytes_sent < ITEM_TARGET / 3) random_message();
    send_idle_pct = 79;
    recv_idle_pct = 30;
    while (bytes_sent < 2 * ITEM_TARGET / 3) random_message();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    while (bytes_sent < ITEM_TARGET) random_message();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    // two compressions plus the output step fit well inside this
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("sha256_byte_stream_hasher_core test passed");
    else
      $display("sha256_byte_stream_hasher_core test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sha_pkg.sv
rtl/core/sha_round.sv
rtl/core/sha256_byte_stream_hasher_core.sv
rtl/core/sha_chk.sv
test/sha256_digest_checker.sv
test/testbench.sv
